// ----- rtl/core/ccar_pkg.sv -----
// Shared types and constants of the cell color attribute resolver.
// Depends on nothing; imported by ccar_init, ccar_mode, the top level and the testbench.
package ccar_pkg;

    localparam int PAL_DEPTH = 266;
    localparam int PAL_AW    = 9;
    localparam int RGB_W     = 24;

    localparam logic [PAL_AW-1:0] IDX_DEF_FG        = 9'd256;
    localparam logic [PAL_AW-1:0] IDX_DEF_BG        = 9'd257;
    localparam logic [PAL_AW-1:0] IDX_DEF_HI_FG     = 9'd258;
    localparam logic [PAL_AW-1:0] IDX_DEF_HI_BG     = 9'd259;
    localparam logic [PAL_AW-1:0] IDX_BOLD_FG       = 9'd260;
    localparam logic [PAL_AW-1:0] IDX_UNDER_FG      = 9'd261;
    localparam logic [PAL_AW-1:0] IDX_BOLD_UNDER_FG = 9'd262;
    localparam logic [PAL_AW-1:0] IDX_HIGH_STEP     = 9'd3;
    localparam logic [PAL_AW-1:0] IDX_BRIGHT_STEP   = 9'd8;
    localparam logic [PAL_AW-1:0] IDX_LAST          = 9'd265;

    localparam logic [15:0] LUM_R = 16'd19660;
    localparam logic [15:0] LUM_G = 16'd38666;
    localparam logic [15:0] LUM_B = 16'd7208;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_AMBER  = 3'd1,
        MODE_GREY   = 3'd2,
        MODE_GREEN  = 3'd3,
        MODE_TINT   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_COLOR_MODE   = 3'd0,
        REG_UNDER_EN     = 3'd1,
        REG_GLOBAL_INV   = 3'd2,
        REG_SEL_FG       = 3'd3,
        REG_SEL_BG       = 3'd4,
        REG_AMBER_FG     = 3'd5,
        REG_AMBER_BG     = 3'd6
    } t_reg;

    typedef struct packed {
        logic             swap;
        logic             sel;
        logic             under;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]       color_mode;
        logic [RGB_W-1:0] sel_fg;
        logic [RGB_W-1:0] sel_bg;
        logic [RGB_W-1:0] amber_fg;
        logic [RGB_W-1:0] amber_bg;
    } t_mode_cfg;

    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [RGB_W-1:0]  data;
    } t_pal_wr;

endpackage

// ----- rtl/core/ccar_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module ccar_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 266
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/ccar_init.sv -----
// Post-reset sweep that loads the default 256-color table and special entries.
// Depends on ccar_pkg.
module ccar_init (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output ccar_pkg::t_pal_wr o_wr,
    output logic              o_busy
);
    import ccar_pkg::*;

    logic [23:0] base16 [16];
    logic [23:0] special10 [10];

    assign base16 = '{24'h000000, 24'hb21818, 24'h18b218, 24'hb26818,
                      24'h1818b2, 24'hb218b2, 24'h18b2b2, 24'hb2b2b2,
                      24'h686868, 24'hff5454, 24'h54ff54, 24'hffff54,
                      24'h5454ff, 24'hff54ff, 24'h54ffff, 24'hffffff};
    assign special10 = '{24'hb2b2b2, 24'h000000, 24'hffffff, 24'h000000,
                         24'h00afaf, 24'h00af00, 24'hafaf00, 24'h00ffff,
                         24'h44ff00, 24'hffff44};

    function automatic logic [7:0] cube_level(input logic [2:0] k);
        logic [7:0] lvl;
        case (k)
            3'd1:    lvl = 8'h5f;
            3'd2:    lvl = 8'h87;
            3'd3:    lvl = 8'haf;
            3'd4:    lvl = 8'hd7;
            3'd5:    lvl = 8'hff;
            default: lvl = 8'h00;
        endcase
        return lvl;
    endfunction

    logic              r_active;
    logic [PAL_AW-1:0] r_idx;
    logic [2:0]        r_cr, r_cg, r_cb;
    logic [7:0]        r_grey;
    logic              in_cube, in_grey;
    logic [23:0]       n_data;

    assign in_cube = (r_idx >= 9'd16) && (r_idx < 9'd232);
    assign in_grey = (r_idx >= 9'd232) && (r_idx < 9'd256);

    always_comb begin
        if (r_idx < 9'd16) begin
            n_data = base16[r_idx[3:0]];
        end else if (in_cube) begin
            n_data = {cube_level(r_cr), cube_level(r_cg), cube_level(r_cb)};
        end else if (in_grey) begin
            n_data = {r_grey, r_grey, r_grey};
        end else if (r_idx <= IDX_LAST) begin
            n_data = special10[r_idx[3:0]];
        end else begin
            n_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_idx    <= '0;
            r_cr     <= '0;
            r_cg     <= '0;
            r_cb     <= '0;
            r_grey   <= 8'h08;
        end else if (r_active) begin
            r_idx <= r_idx + 9'd1;
            if (r_idx == IDX_LAST) begin
                r_active <= 1'b0;
            end
            if (in_cube) begin
                if (r_cb == 3'd5) begin
                    r_cb <= '0;
                    if (r_cg == 3'd5) begin
                        r_cg <= '0;
                        r_cr <= r_cr + 3'd1;
                    end else begin
                        r_cg <= r_cg + 3'd1;
                    end
                end else begin
                    r_cb <= r_cb + 3'd1;
                end
            end
            if (in_grey) begin
                r_grey <= r_grey + 8'h0a;
            end
        end
    end

    assign o_wr.en   = r_active;
    assign o_wr.addr = r_idx;
    assign o_wr.data = n_data;
    assign o_busy    = r_active;

endmodule

// ----- rtl/core/ccar_mode.sv -----
// Monochrome mode transform, inverse swap and selection override, two stages
// plus output register. Depends on ccar_pkg.
module ccar_mode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [23:0]          i_fg,
    input  logic [23:0]          i_bg,
    input  ccar_pkg::t_cell_ctl  i_ctl,
    input  ccar_pkg::t_mode_cfg  i_cfg,
    output logic                 o_valid,
    output logic [23:0]          o_fg,
    output logic [23:0]          o_bg,
    output logic                 o_under
);
    import ccar_pkg::*;

    logic        r_m1_valid, r_m2_valid, r_valid;
    logic [23:0] r_m1_fg, r_m1_bg, r_m2_fg, r_m2_bg;
    t_cell_ctl   r_m1_ctl, r_m2_ctl;
    logic [23:0] r_pf_r, r_pf_g, r_pf_b, r_pb_r, r_pb_g, r_pb_b;
    logic [23:0] r_fg, r_bg;
    logic        r_under;
    logic [23:0] n_fg, n_bg, a_col, b_col;
    logic [7:0]  lum_a, lum_b;

    function automatic logic [7:0] lum_sat(input logic [23:0] pr, input logic [23:0] pg,
                                           input logic [23:0] pb);
        logic [25:0] s;
        s = {2'b00, pr} + {2'b00, pg} + {2'b00, pb};
        return (|s[25:24]) ? 8'hff : s[23:16];
    endfunction

    function automatic logic [23:0] apply(input logic [23:0] c, input logic [7:0] lum,
                                          input logic [23:0] amb, input logic [2:0] mode);
        logic [23:0] res;
        case (mode)
            MODE_AMBER: res = amb;
            MODE_GREY:  res = {lum, lum, lum};
            MODE_GREEN: res = {8'h00, lum, 8'h00};
            MODE_TINT:  begin
                if (lum[7]) begin
                    res = amb;
                end else begin
                    res = {amb[23:16] >> 1, amb[15:8] >> 1, amb[7:0] >> 1};
                end
            end
            default:    res = c;
        endcase
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        r_m1_fg  <= i_fg;
        r_m1_bg  <= i_bg;
        r_m1_ctl <= i_ctl;
        r_m2_fg  <= r_m1_fg;
        r_m2_bg  <= r_m1_bg;
        r_m2_ctl <= r_m1_ctl;
        r_pf_r   <= {8'd0, LUM_R} * {16'd0, r_m1_fg[23:16]};
        r_pf_g   <= {8'd0, LUM_G} * {16'd0, r_m1_fg[15:8]};
        r_pf_b   <= {8'd0, LUM_B} * {16'd0, r_m1_fg[7:0]};
        r_pb_r   <= {8'd0, LUM_R} * {16'd0, r_m1_bg[23:16]};
        r_pb_g   <= {8'd0, LUM_G} * {16'd0, r_m1_bg[15:8]};
        r_pb_b   <= {8'd0, LUM_B} * {16'd0, r_m1_bg[7:0]};
        r_fg     <= n_fg;
        r_bg     <= n_bg;
        r_under  <= r_m2_ctl.under & ~r_m2_ctl.sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_m1_valid <= i_valid;
            r_m2_valid <= r_m1_valid;
            r_valid    <= r_m2_valid;
        end
    end

    always_comb begin
        lum_a = lum_sat(r_pf_r, r_pf_g, r_pf_b);
        lum_b = lum_sat(r_pb_r, r_pb_g, r_pb_b);
        a_col = apply(r_m2_fg, lum_a, i_cfg.amber_fg, i_cfg.color_mode);
        b_col = apply(r_m2_bg, lum_b, i_cfg.amber_bg, i_cfg.color_mode);
        if (r_m2_ctl.sel) begin
            n_fg = i_cfg.sel_fg;
            n_bg = i_cfg.sel_bg;
        end else if (r_m2_ctl.swap) begin
            n_fg = b_col;
            n_bg = a_col;
        end else begin
            n_fg = a_col;
            n_bg = b_col;
        end
    end

    assign o_valid = r_valid;
    assign o_fg    = r_fg;
    assign o_bg    = r_bg;
    assign o_under = r_under;

endmodule

// ----- rtl/core/cell_color_attribute_resolver.sv -----
// Top level of the cell color attribute resolver: register port, palette
// memories, index stage. Depends on ccar_pkg, ccar_ram, ccar_init, ccar_mode.
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+------------------------------------
//  request   | start, busy                   | i_req_type .. i_selected
//  result    | o_valid (one-cycle strobe)    | o_fg_rgb, o_bg_rgb, o_underline_on
//  registers | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One request per cycle while busy is low; a resolve passes the s1, m1, m2 and output registers.
// Palette writes take effect for any later request, the next cycle included.
// After reset busy stays high while the palette sweep loads defaults into all 266 entries.
// Results cannot be stalled; the pipeline never holds requests back.
module cell_color_attribute_resolver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [8:0]  i_pal_index,
    input  logic [23:0] i_pal_rgb,
    input  logic        i_fg_indexed,
    input  logic [23:0] i_fg_value,
    input  logic        i_bg_indexed,
    input  logic [23:0] i_bg_value,
    input  logic        i_bold,
    input  logic        i_underline,
    input  logic        i_blink,
    input  logic        i_inverse,
    input  logic        i_selected,
    output logic        o_valid,
    output logic [23:0] o_fg_rgb,
    output logic [23:0] o_bg_rgb,
    output logic        o_underline_on,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ccar_pkg::*;

    logic [2:0]  r_color_mode;
    logic        r_under_en, r_global_inv;
    logic [23:0] r_sel_fg, r_sel_bg, r_amber_fg, r_amber_bg;
    logic        cfg_we;
    t_reg        reg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite;
    assign reg_sel = t_reg'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= MODE_NORMAL;
            r_under_en   <= 1'b1;
            r_global_inv <= 1'b0;
            r_sel_fg     <= 24'hffffff;
            r_sel_bg     <= 24'h0055cc;
            r_amber_fg   <= 24'hffaa00;
            r_amber_bg   <= 24'h333333;
        end else if (cfg_we) begin
            unique case (reg_sel)
                REG_COLOR_MODE: r_color_mode <= pwdata[2:0];
                REG_UNDER_EN:   r_under_en   <= pwdata[0];
                REG_GLOBAL_INV: r_global_inv <= pwdata[0];
                REG_SEL_FG:     r_sel_fg     <= pwdata[23:0];
                REG_SEL_BG:     r_sel_bg     <= pwdata[23:0];
                REG_AMBER_FG:   r_amber_fg   <= pwdata[23:0];
                REG_AMBER_BG:   r_amber_bg   <= pwdata[23:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_COLOR_MODE: prdata = {29'd0, r_color_mode};
            REG_UNDER_EN:   prdata = {31'd0, r_under_en};
            REG_GLOBAL_INV: prdata = {31'd0, r_global_inv};
            REG_SEL_FG:     prdata = {8'd0, r_sel_fg};
            REG_SEL_BG:     prdata = {8'd0, r_sel_bg};
            REG_AMBER_FG:   prdata = {8'd0, r_amber_fg};
            REG_AMBER_BG:   prdata = {8'd0, r_amber_bg};
            default:        prdata = '0;
        endcase
    end

    t_pal_wr     init_wr, pal_wr;
    logic        init_busy, accept;
    logic [PAL_AW-1:0] fg_addr, bg_addr;
    logic        fg_under;
    logic [23:0] fg_ram, bg_ram;

    ccar_init u_init (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (init_wr),
        .o_busy  (init_busy)
    );

    assign busy   = init_busy;
    assign accept = start & ~init_busy;

    always_comb begin
        if (init_wr.en) begin
            pal_wr = init_wr;
        end else begin
            pal_wr.en   = accept & ~i_req_type & (i_pal_index <= IDX_LAST);
            pal_wr.addr = i_pal_index;
            pal_wr.data = i_pal_rgb;
        end
    end

    always_comb begin
        logic fg_big, bg_big, high;
        fg_big   = |i_fg_value[23:8];
        bg_big   = |i_bg_value[23:8];
        fg_under = 1'b0;
        high     = i_blink;
        fg_addr  = fg_big ? IDX_DEF_FG : {1'b0, i_fg_value[7:0]};
        if (i_bold) begin
            if (fg_big) begin
                fg_addr = (i_underline ? IDX_BOLD_UNDER_FG : IDX_BOLD_FG)
                        + (i_blink ? IDX_HIGH_STEP : '0);
            end else begin
                high = 1'b1;
                if (fg_addr >= IDX_BRIGHT_STEP && r_under_en && i_underline) begin
                    fg_under = 1'b1;
                end
            end
        end else if (i_underline) begin
            if (fg_big) begin
                fg_addr = IDX_UNDER_FG + (i_blink ? IDX_HIGH_STEP : '0);
            end else if (r_under_en) begin
                fg_under = 1'b1;
            end
        end
        if (high) begin
            if (fg_addr < IDX_BRIGHT_STEP) begin
                fg_addr = fg_addr + IDX_BRIGHT_STEP;
            end else if (fg_addr == IDX_DEF_FG) begin
                fg_addr = IDX_DEF_HI_FG;
            end
        end
        fg_under = fg_under & i_fg_indexed;

        bg_addr = bg_big ? IDX_DEF_BG : {1'b0, i_bg_value[7:0]};
        if (i_blink) begin
            if (bg_addr < IDX_BRIGHT_STEP) begin
                bg_addr = bg_addr + IDX_BRIGHT_STEP;
            end else if (bg_addr == IDX_DEF_BG) begin
                bg_addr = IDX_DEF_HI_BG;
            end
        end
    end

    ccar_ram #(.WIDTH(RGB_W), .DEPTH(PAL_DEPTH)) u_pal_fg (
        .i_clk   (i_clk),
        .i_we    (pal_wr.en),
        .i_waddr (pal_wr.addr),
        .i_wdata (pal_wr.data),
        .i_raddr (fg_addr),
        .o_rdata (fg_ram)
    );

    ccar_ram #(.WIDTH(RGB_W), .DEPTH(PAL_DEPTH)) u_pal_bg (
        .i_clk   (i_clk),
        .i_we    (pal_wr.en),
        .i_waddr (pal_wr.addr),
        .i_wdata (pal_wr.data),
        .i_raddr (bg_addr),
        .o_rdata (bg_ram)
    );

    logic        r_s1_valid, r_s1_fg_ix, r_s1_bg_ix;
    logic [23:0] r_s1_fg_val, r_s1_bg_val;
    t_cell_ctl   r_s1_ctl;
    t_mode_cfg   mode_cfg;
    logic [23:0] s1_fg, s1_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept & i_req_type;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_fg_ix     <= i_fg_indexed;
        r_s1_bg_ix     <= i_bg_indexed;
        r_s1_fg_val    <= i_fg_value;
        r_s1_bg_val    <= i_bg_value;
        r_s1_ctl.swap  <= i_inverse ^ r_global_inv;
        r_s1_ctl.sel   <= i_selected;
        r_s1_ctl.under <= fg_under;
    end

    assign s1_fg = r_s1_fg_ix ? fg_ram : r_s1_fg_val;
    assign s1_bg = r_s1_bg_ix ? bg_ram : r_s1_bg_val;

    assign mode_cfg.color_mode = r_color_mode;
    assign mode_cfg.sel_fg     = r_sel_fg;
    assign mode_cfg.sel_bg     = r_sel_bg;
    assign mode_cfg.amber_fg   = r_amber_fg;
    assign mode_cfg.amber_bg   = r_amber_bg;

    ccar_mode u_mode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_fg    (s1_fg),
        .i_bg    (s1_bg),
        .i_ctl   (r_s1_ctl),
        .i_cfg   (mode_cfg),
        .o_valid (o_valid),
        .o_fg    (o_fg_rgb),
        .o_bg    (o_bg_rgb),
        .o_under (o_underline_on)
    );

endmodule

// ----- rtl/core/ccar_checker.sv -----
// Port-level checks of the cell color attribute resolver and their bind.
// Depends on cell_color_attribute_resolver.
module ccar_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_req_type,
    input logic o_valid
);

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low right after reset");

    a_busy_rises_on_reset: assert property (@(posedge i_clk)
        $rose(busy) |-> $past(!i_rst_n))
        else $error("busy rose without reset");

    a_resolve_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |-> ##4 o_valid)
        else $error("resolve request lost");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_req_type, 4))
        else $error("result without resolve request");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result during palette sweep");

endmodule

bind cell_color_attribute_resolver ccar_checker u_ccar_checker (.*);

// ----- tb/cell_color_attribute_resolver_tb.sv -----
// Self-checking testbench of cell_color_attribute_resolver: palette writes and cell resolves
// with random gaps, register phases over all color modes. Depends on ccar_pkg and the resolver.
module cell_color_attribute_resolver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ccar_pkg::*;

    localparam logic       REQ_PAL_WRITE = 1'b0;
    localparam logic       REQ_RESOLVE   = 1'b1;
    localparam logic [2:0] MODE_RESERVED = 3'd7;
    localparam logic [4:0] ATTR_BOLD     = 5'b10000;
    localparam logic [4:0] ATTR_UNDER    = 5'b01000;
    localparam logic [4:0] ATTR_BLINK    = 5'b00100;
    localparam logic [4:0] ATTR_INV      = 5'b00010;
    localparam logic [4:0] ATTR_SEL      = 5'b00001;
    localparam int         DRAIN_CYCLES  = 10;
    localparam int         NUM_PHASES    = 8;
    localparam int         PHASE_ITEMS   = 180;

    typedef struct {
        logic        req_type;
        logic [8:0]  pal_index;
        logic [23:0] pal_rgb;
        logic        fg_indexed;
        logic [23:0] fg_value;
        logic        bg_indexed;
        logic [23:0] bg_value;
        logic        bold;
        logic        underline;
        logic        blink;
        logic        inverse;
        logic        selected;
    } t_cell_req;

    typedef struct {
        logic [23:0] fg;
        logic [23:0] bg;
        logic        ul;
    } t_cell_colors;

    bit          i_clk;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic        i_req_type     = 1'b0;
    logic [8:0]  i_pal_index    = '0;
    logic [23:0] i_pal_rgb      = '0;
    logic        i_fg_indexed   = 1'b0;
    logic [23:0] i_fg_value     = '0;
    logic        i_bg_indexed   = 1'b0;
    logic [23:0] i_bg_value     = '0;
    logic        i_bold         = 1'b0;
    logic        i_underline    = 1'b0;
    logic        i_blink        = 1'b0;
    logic        i_inverse      = 1'b0;
    logic        i_selected     = 1'b0;
    logic        o_valid;
    logic [23:0] o_fg_rgb;
    logic [23:0] o_bg_rgb;
    logic        o_underline_on;
    logic        psel           = 1'b0;
    logic        penable        = 1'b0;
    logic        pwrite         = 1'b0;
    logic [4:0]  paddr          = '0;
    logic [31:0] pwdata         = '0;
    logic [31:0] prdata;
    logic        pready;

    cell_color_attribute_resolver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_pal_index    (i_pal_index),
        .i_pal_rgb      (i_pal_rgb),
        .i_fg_indexed   (i_fg_indexed),
        .i_fg_value     (i_fg_value),
        .i_bg_indexed   (i_bg_indexed),
        .i_bg_value     (i_bg_value),
        .i_bold         (i_bold),
        .i_underline    (i_underline),
        .i_blink        (i_blink),
        .i_inverse      (i_inverse),
        .i_selected     (i_selected),
        .o_valid        (o_valid),
        .o_fg_rgb       (o_fg_rgb),
        .o_bg_rgb       (o_bg_rgb),
        .o_underline_on (o_underline_on),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // palette and register image of the block
    logic [23:0]  pal_model [PAL_DEPTH];
    logic [2:0]   cfg_mode     = MODE_NORMAL;
    logic         cfg_under_en = 1'b1;
    logic         cfg_ginv     = 1'b0;
    logic [23:0]  cfg_sel_fg   = 24'hffffff;
    logic [23:0]  cfg_sel_bg   = 24'h0055cc;
    logic [23:0]  cfg_amber_fg = 24'hffaa00;
    logic [23:0]  cfg_amber_bg = 24'h333333;

    t_cell_req    cell_req_q [$];
    t_cell_colors color_due_q [$];
    t_cell_req    drv_req;
    t_cell_colors mon_col;
    t_cell_colors mon_due;
    logic         taken     = 1'b0;
    int           gap_left  = 0;
    int           max_gap   = 0;
    int           mismatches = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void load_palette_defaults();
        logic [23:0] base16 [16];
        logic [23:0] special [10];
        logic [7:0]  lv [6];
        logic [7:0]  g;
        int          n;
        base16 = '{24'h000000, 24'hb21818, 24'h18b218, 24'hb26818,
                   24'h1818b2, 24'hb218b2, 24'h18b2b2, 24'hb2b2b2,
                   24'h686868, 24'hff5454, 24'h54ff54, 24'hffff54,
                   24'h5454ff, 24'hff54ff, 24'h54ffff, 24'hffffff};
        special = '{24'hb2b2b2, 24'h000000, 24'hffffff, 24'h000000, 24'h00afaf,
                    24'h00af00, 24'hafaf00, 24'h00ffff, 24'h44ff00, 24'hffff44};
        for (int k = 0; k < 6; k++)
            lv[k] = (k == 0) ? 8'h00 : 8'(8'h37 + 8'h28 * k);
        for (int k = 0; k < 16; k++)
            pal_model[k] = base16[k];
        n = 16;
        for (int r = 0; r < 6; r++)
            for (int gg = 0; gg < 6; gg++)
                for (int b = 0; b < 6; b++) begin
                    pal_model[n] = {lv[r], lv[gg], lv[b]};
                    n++;
                end
        for (int k = 0; k < 24; k++) begin
            g = 8'(8'h08 + 8'h0a * k);
            pal_model[n] = {g, g, g};
            n++;
        end
        for (int k = 0; k < 10; k++)
            pal_model[IDX_DEF_FG + k] = special[k];
    endfunction

    function automatic logic [23:0] resolve_color_word(logic indexed, logic [23:0] v,
            logic is_fg, logic bold, logic und, logic blink, output logic ul);
        int unsigned c;
        int unsigned lumi;
        int unsigned sh;
        logic        high;
        logic [23:0] rgb;
        logic [23:0] x;
        ul = 1'b0;
        c = 32'(v);
        high = blink;
        if (indexed) begin
            if (c > 255) c = is_fg ? IDX_DEF_FG : IDX_DEF_BG;
            if (is_fg) begin
                if (bold) begin
                    if (c > 255) begin
                        c = (und ? IDX_BOLD_UNDER_FG : IDX_BOLD_FG);
                        if (high) c = c + IDX_HIGH_STEP;
                    end else begin
                        high = 1'b1;
                        if (c >= IDX_BRIGHT_STEP && cfg_under_en && und) ul = 1'b1;
                    end
                end else if (und) begin
                    if (c > 255) begin
                        c = IDX_UNDER_FG;
                        if (high) c = c + IDX_HIGH_STEP;
                    end else if (cfg_under_en) begin
                        ul = 1'b1;
                    end
                end
            end
            if (high) begin
                if (c < IDX_BRIGHT_STEP) c = c + IDX_BRIGHT_STEP;
                else if (c == IDX_DEF_FG || c == IDX_DEF_BG) c = c + 2;
            end
            c = (c < PAL_DEPTH) ? 32'(pal_model[c]) : 0;
        end
        rgb = c[23:0];
        x = is_fg ? cfg_amber_fg : cfg_amber_bg;
        case (cfg_mode)
            MODE_AMBER: begin
                rgb = x;
            end
            MODE_GREY, MODE_GREEN, MODE_TINT: begin
                lumi = (32'(LUM_R) * 32'(rgb[23:16]) + 32'(LUM_G) * 32'(rgb[15:8])
                        + 32'(LUM_B) * 32'(rgb[7:0])) >> 16;
                if (lumi > 255) lumi = 255;
                if (cfg_mode == MODE_GREY) begin
                    rgb = {3{lumi[7:0]}};
                end else if (cfg_mode == MODE_GREEN) begin
                    rgb = {8'h00, lumi[7:0], 8'h00};
                end else begin
                    sh = lumi[7] ? 0 : 1;
                    rgb = {x[23:16] >> sh, x[15:8] >> sh, x[7:0] >> sh};
                end
            end
            default: ;
        endcase
        return rgb;
    endfunction

    // update the palette image or work out the colors of one request
    function automatic logic resolve_cell_colors(t_cell_req r, output t_cell_colors col);
        logic [23:0] a;
        logic [23:0] b;
        logic        ul_a;
        logic        ul_b;
        col = '{fg: '0, bg: '0, ul: 1'b0};
        if (r.req_type == REQ_PAL_WRITE) begin
            if (r.pal_index <= IDX_LAST) pal_model[r.pal_index] = r.pal_rgb;
            return 1'b0;
        end
        if (r.selected) begin
            col.fg = cfg_sel_fg;
            col.bg = cfg_sel_bg;
        end else begin
            a = resolve_color_word(r.fg_indexed, r.fg_value, 1'b1, r.bold, r.underline,
                                   r.blink, ul_a);
            b = resolve_color_word(r.bg_indexed, r.bg_value, 1'b0, r.bold, r.underline,
                                   r.blink, ul_b);
            if (r.inverse != cfg_ginv) begin
                col.fg = b;
                col.bg = a;
            end else begin
                col.fg = a;
                col.bg = b;
            end
            col.ul = ul_a | ul_b;
        end
        return 1'b1;
    endfunction

    function automatic logic [23:0] rand_color_word(logic indexed);
        if (!indexed) return 24'($urandom);
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 15));
            1: return 24'($urandom_range(16, 255));
            2: return 24'($urandom_range(256, 511));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_cell_req rand_cell();
        t_cell_req r;
        r.req_type   = ($urandom_range(0, 99) < 15) ? REQ_PAL_WRITE : REQ_RESOLVE;
        r.pal_index  = ($urandom_range(0, 3) == 0) ? 9'($urandom)
                                                   : 9'($urandom_range(0, IDX_LAST));
        r.pal_rgb    = 24'($urandom);
        r.fg_indexed = 1'($urandom);
        r.fg_value   = rand_color_word(r.fg_indexed);
        r.bg_indexed = 1'($urandom);
        r.bg_value   = rand_color_word(r.bg_indexed);
        {r.bold, r.underline, r.blink, r.inverse} = 4'($urandom);
        r.selected   = ($urandom_range(0, 7) == 0);
        return r;
    endfunction

    function automatic t_cell_req cell_resolve(logic fi, logic [23:0] fv, logic bi,
            logic [23:0] bv, logic [4:0] attr);
        t_cell_req r;
        r = rand_cell();
        r.req_type   = REQ_RESOLVE;
        r.fg_indexed = fi;
        r.fg_value   = fv;
        r.bg_indexed = bi;
        r.bg_value   = bv;
        {r.bold, r.underline, r.blink, r.inverse, r.selected} = attr;
        return r;
    endfunction

    function automatic t_cell_req cell_pal_write(logic [8:0] idx, logic [23:0] rgb);
        t_cell_req r;
        r = rand_cell();
        r.req_type  = REQ_PAL_WRITE;
        r.pal_index = idx;
        r.pal_rgb   = rgb;
        return r;
    endfunction

    function automatic logic [23:0] phase_rgb(int p);
        if (p == 1) return 24'h000000;
        if (p == NUM_PHASES - 1) return 24'hffffff;
        return 24'($urandom);
    endfunction

    task automatic write_reg(t_reg r, logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (r)
            REG_COLOR_MODE: cfg_mode     = v[2:0];
            REG_UNDER_EN:   cfg_under_en = v[0];
            REG_GLOBAL_INV: cfg_ginv     = v[0];
            REG_SEL_FG:     cfg_sel_fg   = v[23:0];
            REG_SEL_BG:     cfg_sel_bg   = v[23:0];
            REG_AMBER_FG:   cfg_amber_fg = v[23:0];
            REG_AMBER_BG:   cfg_amber_bg = v[23:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold until every request is taken and every result is in, then let the pipe drain
    task automatic settle();
        while (cell_req_q.size() != 0 || start || color_due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!(start && !taken)) begin
            if (start) gap_left = $urandom_range(0, max_gap);
            if (gap_left != 0 || cell_req_q.size() == 0) begin
                if (gap_left != 0) gap_left--;
                start <= 1'b0;
            end else begin
                drv_req = cell_req_q.pop_front();
                i_req_type   <= drv_req.req_type;
                i_pal_index  <= drv_req.pal_index;
                i_pal_rgb    <= drv_req.pal_rgb;
                i_fg_indexed <= drv_req.fg_indexed;
                i_fg_value   <= drv_req.fg_value;
                i_bg_indexed <= drv_req.bg_indexed;
                i_bg_value   <= drv_req.bg_value;
                i_bold       <= drv_req.bold;
                i_underline  <= drv_req.underline;
                i_blink      <= drv_req.blink;
                i_inverse    <= drv_req.inverse;
                i_selected   <= drv_req.selected;
                start        <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        taken <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            if (resolve_cell_colors(drv_req, mon_col)) color_due_q.push_back(mon_col);
        end
        if (i_rst_n && o_valid) begin
            if (color_due_q.size() == 0) begin
                $error("result with no request pending: fg_rgb %06h bg_rgb %06h",
                       o_fg_rgb, o_bg_rgb);
                mismatches++;
            end else begin
                mon_due = color_due_q.pop_front();
                if (o_fg_rgb !== mon_due.fg) begin
                    $error("fg_rgb: expected %06h, actual %06h", mon_due.fg, o_fg_rgb);
                    mismatches++;
                end
                if (o_bg_rgb !== mon_due.bg) begin
                    $error("bg_rgb: expected %06h, actual %06h", mon_due.bg, o_bg_rgb);
                    mismatches++;
                end
                if (o_underline_on !== mon_due.ul) begin
                    $error("underline_on: expected %0b, actual %0b", mon_due.ul,
                           o_underline_on);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #400_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic [2:0] modes [NUM_PHASES];
        modes = '{MODE_NORMAL, MODE_AMBER, MODE_GREY, MODE_GREEN, MODE_TINT,
                  MODE_RESERVED, MODE_GREY, MODE_TINT};
        load_palette_defaults();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);

        max_gap = 0;
        cell_req_q.push_back(cell_resolve(1'b0, 24'hffffff, 1'b0, 24'h000000, 5'b0));
        cell_req_q.push_back(cell_resolve(1'b0, 24'h000000, 1'b0, 24'hffffff, ATTR_INV));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd0, 1'b1, 24'd15, ATTR_BOLD));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd3, 1'b1, 24'd2, ATTR_BOLD | ATTR_UNDER));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd9, 1'b1, 24'd200,
                                          ATTR_BOLD | ATTR_UNDER));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd7, 1'b1, 24'd7,
                                          ATTR_UNDER | ATTR_BLINK));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd300, 1'b1, 24'd300, ATTR_BOLD));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd256, 1'b0, 24'h123456,
                                          ATTR_BOLD | ATTR_UNDER));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd511, 1'b1, 24'd1,
                                          ATTR_BOLD | ATTR_UNDER | ATTR_BLINK));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd400, 1'b1, 24'd4, ATTR_UNDER));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd400, 1'b1, 24'd4,
                                          ATTR_UNDER | ATTR_BLINK));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd257, 1'b1, 24'd257, ATTR_BLINK));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd255, 1'b1, 24'd256, 5'b0));
        cell_req_q.push_back(cell_resolve(1'b1, 24'hffffff, 1'b1, 24'hffffff, ATTR_INV));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd1, 1'b1, 24'd5, ATTR_BLINK));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd9, 1'b1, 24'd9,
                                          ATTR_BOLD | ATTR_UNDER | ATTR_BLINK
                                          | ATTR_INV | ATTR_SEL));
        cell_req_q.push_back(cell_pal_write(9'd0, 24'h123456));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd0, 1'b1, 24'd0, 5'b0));
        cell_req_q.push_back(cell_pal_write(IDX_LAST, 24'ha5a5a5));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd300, 1'b1, 24'd0,
                                          ATTR_BOLD | ATTR_UNDER | ATTR_BLINK));
        cell_req_q.push_back(cell_pal_write(9'd266, 24'hffffff));
        cell_req_q.push_back(cell_pal_write(9'd511, 24'h000000));
        cell_req_q.push_back(cell_pal_write(IDX_DEF_FG, 24'h5a5a5a));
        cell_req_q.push_back(cell_resolve(1'b1, 24'd256, 1'b1, 24'd256, ATTR_INV));

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            max_gap = (p % 3 == 2) ? 0 : 6;
            write_reg(REG_COLOR_MODE, 32'(modes[p]));
            write_reg(REG_UNDER_EN, p[0] ? 32'd0 : 32'd1);
            write_reg(REG_GLOBAL_INV, 32'(p[1]));
            write_reg(REG_SEL_FG, 32'(phase_rgb(p)));
            write_reg(REG_SEL_BG, 32'(phase_rgb(p)));
            write_reg(REG_AMBER_FG, 32'(phase_rgb(p)));
            write_reg(REG_AMBER_BG, 32'(phase_rgb(p)));
            for (int n = 0; n < PHASE_ITEMS; n++)
                cell_req_q.push_back(rand_cell());
        end
        settle();

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
